[hw/rtl/ffpa_pkg.sv]
// Package for the first-fit pool allocator: status codes, field widths and
// the command and status structs between controller and datapath.
// No dependencies.
package ffpa_pkg;

    localparam int OFF_W = 10;
    localparam int SIZE_W = 10;
    localparam int ST_W = 2;
    localparam int MIN_SPLIT = 8;

    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_OFFSET = 2'd2;

    typedef struct packed {
        logic            init;
        logic            accept;
        logic            scan_next;
        logic            hit_alloc;
        logic            merge_start;
        logic            merge_step;
        logic            merge_fin;
        logic            shift_step;
        logic            split_new;
        logic            split_old;
        logic            resp;
        logic [ST_W-1:0] resp_code;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic split_ok;
        logic shift_more;
        logic action_free;
    } t_stat;

endpackage

[hw/rtl/ffpa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ffpa_ctrl.sv]
// Controller state machine of the pool allocator: sequences scan, shift,
// split and merge passes. Depends on ffpa_pkg.
module ffpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ffpa_pkg::t_stat i_stat,
    output ffpa_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_SPLIT_OLD, S_MERGE, S_MERGE_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    ffpa_pkg::t_cmd cmd;

    always_comb begin
        cmd = '0;
        cmd.resp_code = ffpa_pkg::ST_DONE;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                cmd.init = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (i_stat.action_free) begin
                        cmd.merge_start = 1'b1;
                        n_state = S_MERGE;
                    end else begin
                        cmd.hit_alloc = 1'b1;
                        if (i_stat.split_ok) begin
                            n_state = S_SHIFT;
                        end else begin
                            cmd.resp = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_stat.last) begin
                    cmd.resp = 1'b1;
                    cmd.resp_code = i_stat.action_free ? ffpa_pkg::ST_BAD_OFFSET
                                                       : ffpa_pkg::ST_NO_SPACE;
                    n_state = S_IDLE;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.split_new = 1'b1;
                    n_state = S_SPLIT_OLD;
                end
            end
            S_SPLIT_OLD: begin
                cmd.split_old = 1'b1;
                cmd.resp = 1'b1;
                n_state = S_IDLE;
            end
            S_MERGE: begin
                cmd.merge_step = 1'b1;
                if (i_stat.last) begin
                    n_state = S_MERGE_FIN;
                end
            end
            S_MERGE_FIN: begin
                cmd.merge_fin = 1'b1;
                cmd.resp = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_busy <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy <= (n_state != S_IDLE);
        end
    end

    assign o_cmd = cmd;
    assign o_busy = r_busy;

endmodule

[hw/rtl/ffpa_dp.sv]
// Datapath of the pool allocator: block table RAM, scan and merge indices,
// block count and result registers. Depends on ffpa_pkg and ffpa_ram.
module ffpa_dp #(
    parameter int POOL_BYTES = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffpa_pkg::t_cmd                i_cmd,
    output ffpa_pkg::t_stat               o_stat,
    input  logic                          i_action,
    input  logic [ffpa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffpa_pkg::OFF_W-1:0]    i_payload_offset,
    output logic                          o_valid,
    output logic [ffpa_pkg::ST_W-1:0]     o_status,
    output logic [ffpa_pkg::OFF_W-1:0]    o_granted_offset
);

    localparam int AW = $clog2(POOL_BYTES + 1);
    localparam int SW = ((AW > ffpa_pkg::OFF_W) ? AW : ffpa_pkg::OFF_W) + 2;
    localparam int ES = 2 * AW + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] MINS = SW'(ffpa_pkg::MIN_SPLIT);

    logic          r_action;
    logic [SW-1:0] r_want, r_off;
    logic [IW-1:0] r_idx, r_i;
    logic [CW-1:0] r_cnt, r_j, r_wr;
    logic [ES-1:0] r_ent, r_hold;
    logic          r_hv;
    logic [ffpa_pkg::OFF_W-1:0] r_gnt;
    logic          r_valid;
    logic [ffpa_pkg::ST_W-1:0]  r_status;
    logic [ffpa_pkg::OFF_W-1:0] r_granted;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [ES-1:0] wdata, rdata;

    logic [SW-1:0] e_start, e_size, h_size, o_start, o_size;
    logic          e_free, m_free, merge_join, split_ok;

    ffpa_ram #(.WIDTH(ES), .DEPTH(MAX_BLOCKS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign e_start = SW'(rdata[2*AW:AW+1]);
    assign e_size = SW'(rdata[AW:1]);
    assign e_free = rdata[0];
    assign h_size = SW'(r_hold[AW:1]);
    assign o_start = SW'(r_ent[2*AW:AW+1]);
    assign o_size = SW'(r_ent[AW:1]);
    assign m_free = e_free | (r_idx == r_i);
    assign merge_join = r_hv & r_hold[0] & m_free;
    assign split_ok = (e_size >= r_want + HDR + MINS) && (r_cnt < CW'(MAX_BLOCKS));

    always_comb begin
        o_stat.action_free = r_action;
        o_stat.hit = r_action ? (e_start + HDR == r_off) : (e_free && e_size >= r_want);
        o_stat.last = (CW'(r_idx) == r_cnt - CW'(1));
        o_stat.split_ok = split_ok;
        o_stat.shift_more = (r_j > CW'(r_i) + CW'(1));
    end

    always_comb begin
        if (i_cmd.accept || i_cmd.merge_start) begin
            raddr = '0;
        end else if (i_cmd.scan_next || i_cmd.merge_step) begin
            raddr = r_idx + IW'(1);
        end else if (i_cmd.hit_alloc) begin
            raddr = IW'(r_cnt - CW'(1));
        end else if (i_cmd.shift_step) begin
            raddr = IW'(r_j - CW'(2));
        end else begin
            raddr = r_idx;
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_idx;
        wdata = rdata;
        if (i_cmd.init) begin
            we = 1'b1;
            waddr = '0;
            wdata = {AW'(0), AW'(POOL_BYTES - HEADER_BYTES), 1'b1};
        end else if (i_cmd.hit_alloc && !split_ok) begin
            we = 1'b1;
            wdata = {rdata[ES-1:1], 1'b0};
        end else if (i_cmd.shift_step) begin
            we = 1'b1;
            waddr = IW'(r_j);
        end else if (i_cmd.split_new) begin
            we = 1'b1;
            waddr = r_i + IW'(1);
            wdata = {AW'(o_start + HDR + r_want), AW'(o_size - r_want - HDR), 1'b1};
        end else if (i_cmd.split_old) begin
            we = 1'b1;
            waddr = r_i;
            wdata = {r_ent[2*AW:AW+1], AW'(r_want), 1'b0};
        end else if (i_cmd.merge_step && r_hv && !merge_join) begin
            we = 1'b1;
            waddr = IW'(r_wr);
            wdata = r_hold;
        end else if (i_cmd.merge_fin) begin
            we = 1'b1;
            waddr = IW'(r_wr);
            wdata = r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CW'(1);
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.resp;
            if (i_cmd.init) begin
                r_cnt <= CW'(1);
            end else if (i_cmd.split_old) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.merge_fin) begin
                r_cnt <= r_wr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_want <= SW'(i_req_size);
            r_off <= SW'(i_payload_offset);
            r_idx <= '0;
        end
        if (i_cmd.scan_next || i_cmd.merge_step) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.hit_alloc) begin
            r_i <= r_idx;
            r_ent <= rdata;
            r_j <= r_cnt;
            r_gnt <= ffpa_pkg::OFF_W'(e_start + HDR);
        end
        if (i_cmd.shift_step) begin
            r_j <= r_j - CW'(1);
        end
        if (i_cmd.merge_start) begin
            r_i <= r_idx;
            r_idx <= '0;
            r_wr <= '0;
            r_hv <= 1'b0;
        end
        if (i_cmd.merge_step) begin
            r_hv <= 1'b1;
            if (merge_join) begin
                r_hold <= {r_hold[2*AW:AW+1], AW'(h_size + HDR + e_size), 1'b1};
            end else begin
                r_hold <= {rdata[ES-1:1], m_free};
                if (r_hv) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
        end
        if (i_cmd.resp) begin
            r_status <= i_cmd.resp_code;
            r_granted <= (i_cmd.resp_code == ffpa_pkg::ST_DONE && !r_action)
                         ? (i_cmd.hit_alloc ? ffpa_pkg::OFF_W'(e_start + HDR) : r_gnt)
                         : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_granted_offset = r_granted;

endmodule

[hw/rtl/first_fit_pool_allocator_core.sv]
// Over N blocks, an allocate scans from entry 0 for the first free block that fits; one taken
// whole is marked used, and a split shifts later entries up, writes the free rest, then the old
// entry shrunk. A miss or unknown offset scans all N; a free found at entry i then merges over all
// N, joining adjacent free blocks. Throughput: one item at a time; busy drops with the result
// strobe, so the next item can be taken at the edge that takes the result. Reset: synchronous;
// busy stays high after release while init sets one free block. The result strobe cannot be stalled.
module first_fit_pool_allocator_core #(
    parameter int POOL_BYTES = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [ffpa_pkg::SIZE_W-1:0] i_req_size,
    input  logic [ffpa_pkg::OFF_W-1:0]  i_payload_offset,
    output logic                        o_valid,
    output logic [ffpa_pkg::ST_W-1:0]   o_status,
    output logic [ffpa_pkg::OFF_W-1:0]  o_granted_offset
);

    ffpa_pkg::t_cmd  cmd;
    ffpa_pkg::t_stat stat;

    ffpa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    ffpa_dp #(
        .POOL_BYTES(POOL_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_req_size      (i_req_size),
        .i_payload_offset(i_payload_offset),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_offset(o_granted_offset)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after accept");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without an item in flight");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ffpa_pkg::ST_DONE || o_status == ffpa_pkg::ST_NO_SPACE
                     || o_status == ffpa_pkg::ST_BAD_OFFSET)) else $error("bad status");

endmodule
